/* hdl/mstp_pkg.sv */
// package for the prim minimum spanning tree block
// stream field layout, item kind codes and parameter defaults; no dependencies
`default_nettype none

package mstp_pkg;

    localparam int VERTICES_DEF    = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int IDX_W    = 4;
    localparam int WEIGHT_W = 16;

    // s_tdata: row, col, edge_weight
    localparam int S_ROW_LSB    = 0;
    localparam int S_COL_LSB    = S_ROW_LSB + IDX_W;
    localparam int S_WEIGHT_LSB = S_COL_LSB + IDX_W;
    localparam int S_TDATA_W    = 24;

    // m_tdata: vertex, parent_vertex, tree_weight
    localparam int M_VERTEX_LSB = 0;
    localparam int M_PARENT_LSB = M_VERTEX_LSB + IDX_W;
    localparam int M_WEIGHT_LSB = M_PARENT_LSB + IDX_W;
    localparam int M_TDATA_W    = 24;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

endpackage

`default_nettype wire

/* hdl/mstp_ram.sv */
// simple dual port synchronous ram, one write and one registered read port
// used for the weight matrix and the per vertex records; no dependencies
`default_nettype none

module mstp_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/minimum_spanning_tree_prim.sv */
// Prim minimum spanning tree over a dense adjacency matrix held in ram.
// Load beats (tuser = 0) write one matrix entry each; entries with a row or column
// beyond VERTICES-1 are dropped, and every entry must be loaded before a start. A start beat
// (tuser = 1) runs Prim from vertex 0 and returns one beat per vertex 1..VERTICES-1 in order,
// tlast on the final one. A start makes a clearing pass of the vertex record ram, then per
// round a minimum scan and a relaxation sweep, each walking the single read port of the
// record ram one vertex a cycle, then a read state and a load state per result beat, the
// load waiting while the output is stalled. Input is not taken while a start is being
// worked on.
// depends on mstp_pkg and mstp_ram
`default_nettype none

module minimum_spanning_tree_prim #(
    parameter int VERTICES    = mstp_pkg::VERTICES_DEF,
    parameter int WEIGHT_BITS = mstp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mstp_pkg::S_TDATA_W-1:0] s_tdata,  // row, col, edge_weight
    input  wire logic                           s_tuser,  // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mstp_pkg::M_TDATA_W-1:0] m_tdata,  // vertex, parent_vertex, tree_weight
    output logic                                m_tuser,  // reached
    output logic                                m_tlast
);

    import mstp_pkg::*;

    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int AW = $clog2(VERTICES * VERTICES);
    localparam int WB = WEIGHT_BITS;
    localparam logic [VW-1:0] LAST_IDX = VW'(VERTICES - 1);

    typedef struct packed {
        logic          in_tree;
        logic          key_valid;
        logic [VW-1:0] parent;
        logic [WB-1:0] key;
    } vrec_t;

    localparam int VREC_W = $bits(vrec_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_END,
        ST_RELAX,
        ST_RELAX_END,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    state_t        state_reg;
    logic [VW-1:0] idx_reg;
    logic [VW-1:0] u_reg;
    logic          found_reg;
    logic [WB-1:0] best_reg;
    logic          pipe_valid_reg;
    logic [VW-1:0] pipe_idx_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    // input beat decode
    logic          s_beat;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;
    logic [31:0]   w_ext;
    logic [31:0]   laddr_ext;
    logic          load_we;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_beat    = s_tvalid && s_tready;
    assign row_ext   = 32'(s_tdata[S_ROW_LSB +: IDX_W]);
    assign col_ext   = 32'(s_tdata[S_COL_LSB +: IDX_W]);
    assign w_ext     = 32'(s_tdata[S_WEIGHT_LSB +: WEIGHT_W]);
    assign laddr_ext = row_ext * VERTICES + col_ext;
    assign load_we   = s_beat && (kind_t'(s_tuser) == KIND_LOAD)
                       && (row_ext < VERTICES) && (col_ext < VERTICES);

    // weight matrix
    logic [31:0]   raddr_ext;
    logic [WB-1:0] w_rd;

    assign raddr_ext = 32'(u_reg) * VERTICES + 32'(idx_reg);

    mstp_ram #(
        .DEPTH  (VERTICES * VERTICES),
        .DATA_W (WB)
    ) u_wmem (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (laddr_ext[AW-1:0]),
        .wdata (w_ext[WB-1:0]),
        .raddr (raddr_ext[AW-1:0]),
        .rdata (w_rd)
    );

    // vertex records
    logic              v_we;
    logic [VW-1:0]     v_waddr;
    vrec_t             v_wdata;
    logic [VREC_W-1:0] v_rdata;
    vrec_t             v_rd;

    mstp_ram #(
        .DEPTH  (VERTICES),
        .DATA_W (VREC_W)
    ) u_vmem (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (idx_reg),
        .rdata (v_rdata)
    );

    assign v_rd = vrec_t'(v_rdata);

    // minimum scan
    logic          cand;
    logic          found_next;
    logic [WB-1:0] best_next;
    logic [VW-1:0] u_next;

    assign cand       = pipe_valid_reg && !v_rd.in_tree && v_rd.key_valid
                        && (!found_reg || (v_rd.key < best_reg));
    assign found_next = found_reg || cand;
    assign best_next  = cand ? v_rd.key : best_reg;
    assign u_next     = cand ? pipe_idx_reg : u_reg;

    // relaxation and clearing writes
    logic relax_on;
    logic self_hit;
    logic relax_upd;

    assign relax_on  = pipe_valid_reg
                       && ((state_reg == ST_RELAX) || (state_reg == ST_RELAX_END));
    assign self_hit  = (pipe_idx_reg == u_reg);
    assign relax_upd = (w_rd != '0) && !v_rd.in_tree
                       && (!v_rd.key_valid || (w_rd < v_rd.key));

    always_comb begin
        v_we    = 1'b0;
        v_waddr = pipe_idx_reg;
        v_wdata = v_rd;
        if (state_reg == ST_CLEAR) begin
            v_we              = 1'b1;
            v_waddr           = idx_reg;
            v_wdata.in_tree   = 1'b0;
            v_wdata.key_valid = (idx_reg == '0);
            v_wdata.parent    = '0;
            v_wdata.key       = '0;
        end else if (relax_on && self_hit) begin
            v_we            = 1'b1;
            v_wdata.in_tree = 1'b1;
        end else if (relax_on && relax_upd) begin
            v_we              = 1'b1;
            v_wdata.in_tree   = 1'b0;
            v_wdata.key_valid = 1'b1;
            v_wdata.parent    = u_reg;
            v_wdata.key       = w_rd;
        end
    end

    // result beat fields
    logic [31:0] par_ext;
    logic [31:0] key_ext;
    logic [31:0] idx_ext;
    logic        out_free;

    assign par_ext  = v_rd.in_tree ? 32'(v_rd.parent) : 32'd0;
    assign key_ext  = v_rd.in_tree ? 32'(v_rd.key) : 32'd0;
    assign idx_ext  = 32'(idx_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        pipe_idx_reg <= idx_reg;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            u_reg          <= '0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            pipe_valid_reg <= 1'b0;
        end else begin
            pipe_valid_reg <= (state_reg == ST_SCAN) || (state_reg == ST_RELAX);
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT_LD)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat && (kind_t'(s_tuser) == KIND_START)) begin
                        idx_reg   <= '0;
                        state_reg <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    found_reg <= 1'b0;
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SCAN: begin
                    found_reg <= found_next;
                    best_reg  <= best_next;
                    u_reg     <= u_next;
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_SCAN_END;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SCAN_END: begin
                    u_reg <= u_next;
                    if (found_next) begin
                        idx_reg   <= '0;
                        state_reg <= ST_RELAX;
                    end else begin
                        idx_reg   <= VW'(1);
                        state_reg <= ST_OUT_RD;
                    end
                end
                ST_RELAX: begin
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_RELAX_END;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_RELAX_END: begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= ST_SCAN;
                end
                ST_OUT_RD: begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {key_ext[WEIGHT_W-1:0], par_ext[IDX_W-1:0],
                                         idx_ext[IDX_W-1:0]};
                        m_tuser_reg  <= v_rd.in_tree;
                        m_tlast_reg  <= (idx_reg == LAST_IDX);
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* hdl/mstp_checker.sv */
// port level checks for the prim minimum spanning tree block, bound to the top level
// depends on mstp_pkg and minimum_spanning_tree_prim
`default_nettype none

module mstp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mstp_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser,
    input wire logic                           m_tlast
);

    import mstp_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // unreached vertex carries no parent and no weight
    a_unreached_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[M_TDATA_W-1:M_PARENT_LSB] == '0)
        else $error("unreached vertex with nonzero fields");

    // a tree edge always has a real weight
    a_reached_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[M_WEIGHT_LSB +: WEIGHT_W] != '0)
        else $error("reached vertex with zero edge weight");

    // no input taken while a result run is still being produced
    a_busy_no_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a result run");

    // a start beat makes the input busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (kind_t'(s_tuser) == KIND_START) |=> !s_tready)
        else $error("input ready right after a start beat");

endmodule

bind minimum_spanning_tree_prim mstp_checker u_mstp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
